@@ hw/rtl/ibos_pkg.sv @@
// Shared types and constants for the indirect branch opcode scanner.
// Used by ibos_decode and indirect_branch_opcode_scanner; no dependencies.
package ibos_pkg;

   localparam int POS_WIDTH    = 32;
   localparam int OFFSET_WIDTH = 32;
   localparam int DISP_WIDTH   = 32;
   localparam int WINDOW_DEPTH = 7;
   localparam int HELD_DEPTH   = WINDOW_DEPTH - 1;

   localparam logic [7:0] PREFIX_BYTE  = 8'hFF;
   localparam logic [7:0] SIB_ESP_ONLY = 8'h24;

   localparam logic [2:0] REG_CALL = 3'd2;
   localparam logic [2:0] REG_JMP  = 3'd4;
   localparam logic [2:0] RM_SIB   = 3'd4;

   localparam logic [1:0] MOD_INDIRECT = 2'd0;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP32   = 2'd2;
   localparam logic [1:0] MOD_DIRECT   = 2'd3;

   localparam logic [1:0] MODE_REGISTER = 2'd0;
   localparam logic [1:0] MODE_DISP8    = 2'd1;
   localparam logic [1:0] MODE_DISP32   = 2'd2;

   typedef logic [2:0] count_type;
   typedef logic [WINDOW_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic                         hit;
      logic                         is_jump;
      logic [2:0]                   base_register;
      logic [1:0]                   address_mode;
      logic signed [DISP_WIDTH-1:0] displacement;
   } match_type;

endpackage

@@ hw/rtl/ibos_decode.sv @@
// Decodes one candidate position: 0xFF, ModRM, optional SIB and displacement.
// Depends on ibos_pkg.
module ibos_decode import ibos_pkg::*; (
   input  window_type view,
   input  count_type  avail,
   output match_type  result
);

   logic [7:0]  modrm;
   logic [2:0]  reg_field;
   logic [1:0]  mod_field;
   logic [2:0]  rm_field;
   logic        has_sib;
   count_type   need;
   logic [7:0]  disp8;
   logic [31:0] disp32;
   logic        sib_ok;

   always_comb begin
      modrm     = view[1];
      reg_field = modrm[5:3];
      mod_field = modrm[7:6];
      rm_field  = modrm[2:0];
      has_sib   = (rm_field == RM_SIB);
      disp8     = has_sib ? view[3] : view[2];
      disp32    = has_sib ? {view[6], view[5], view[4], view[3]}
                          : {view[5], view[4], view[3], view[2]};
      sib_ok    = !has_sib || (mod_field == MOD_DIRECT) || (view[2] == SIB_ESP_ONLY);

      case (mod_field)
         MOD_DISP8: begin
            need = has_sib ? 3'd4 : 3'd3;
         end
         MOD_DISP32: begin
            need = has_sib ? 3'd7 : 3'd6;
         end
         default: begin
            need = 3'd2;
         end
      endcase

      result.hit = (avail >= 3'd2) && (view[0] == PREFIX_BYTE)
                   && ((reg_field == REG_CALL) || (reg_field == REG_JMP))
                   && (mod_field != MOD_INDIRECT) && (avail >= need) && sib_ok;
      result.is_jump       = (reg_field == REG_JMP);
      result.base_register = rm_field;

      case (mod_field)
         MOD_DISP8: begin
            result.address_mode = MODE_DISP8;
            result.displacement = {{(DISP_WIDTH-8){disp8[7]}}, disp8};
         end
         MOD_DISP32: begin
            result.address_mode = MODE_DISP32;
            result.displacement = disp32;
         end
         default: begin
            result.address_mode = MODE_REGISTER;
            result.displacement = '0;
         end
      endcase
   end

endmodule

@@ hw/rtl/indirect_branch_opcode_scanner.sv @@
// Indirect branch opcode scanner: finds x86 indirect call/jmp encodings in a byte stream.
// Path: bytes register into the frame, then each match into the result register.
// Throughput: one byte per cycle unless req_stall; a byte that yields n results holds
// req_stall until the single result register, one match per cycle unless rsp_stall, takes its last.
// Reset: synchronous; empties the window and returns the stream position to zero.
// Depends on ibos_pkg and ibos_decode.
module indirect_branch_opcode_scanner import ibos_pkg::*; (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_end_of_stream,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [OFFSET_WIDTH-1:0]        rsp_match_offset,
   output logic                           rsp_is_jump,
   output logic [2:0]                     rsp_base_register,
   output logic [1:0]                     rsp_address_mode,
   output logic signed [DISP_WIDTH-1:0]   rsp_displacement,
   output logic                           rsp_last_of_run
);

   logic [HELD_DEPTH-1:0][7:0] win_ff;
   count_type                  fill_ff;
   logic [POS_WIDTH-1:0]       pos_ff;

   window_type                 frame_ff;
   count_type                  flen_ff;
   logic [POS_WIDTH-1:0]       fpos_ff;
   logic                       feos_ff;
   logic                       fvalid_ff;
   logic [WINDOW_DEPTH-1:0]    done_ff;

   logic                       rsp_valid_ff;
   logic [OFFSET_WIDTH-1:0]    offset_ff;
   match_type                  result_ff;
   logic                       last_ff;

   window_type                 frame_in;
   count_type                  flen_in;
   logic [POS_WIDTH-1:0]       pos_inc;
   logic                       accept;

   logic [2*WINDOW_DEPTH-1:0][7:0] frame_pad;
   window_type                 views   [WINDOW_DEPTH];
   count_type                  avails  [WINDOW_DEPTH];
   match_type                  results [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0]    match_vec;
   logic [WINDOW_DEPTH-1:0]    remain;
   logic [WINDOW_DEPTH-1:0]    lowest;
   count_type                  sel;
   logic                       last;
   logic                       out_ready;
   logic                       emit;
   logic                       frame_free;
   logic [POS_WIDTH:0]         offset_sum;
   logic [POS_WIDTH-1:0]       offset_sat;

   assign accept = req_valid && !req_stall;

   always_comb begin
      frame_in          = {8'h00, win_ff};
      frame_in[fill_ff] = req_data_byte;
      flen_in           = fill_ff + 3'd1;
      pos_inc           = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
         pos_ff  <= '0;
      end else if (accept) begin
         if (req_end_of_stream) begin
            win_ff  <= '0;
            fill_ff <= '0;
            pos_ff  <= '0;
         end else if (fill_ff == count_type'(HELD_DEPTH)) begin
            win_ff <= frame_in[WINDOW_DEPTH-1:1];
            pos_ff <= pos_inc;
         end else begin
            win_ff  <= frame_in[HELD_DEPTH-1:0];
            fill_ff <= flen_in;
         end
      end
   end

   assign frame_pad = {{WINDOW_DEPTH{8'h00}}, frame_ff};

   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_pos
      assign views[k]  = frame_pad[k +: WINDOW_DEPTH];
      assign avails[k] = (flen_ff > count_type'(k)) ? flen_ff - count_type'(k) : 3'd0;

      ibos_decode u_decode (
         .view   (views[k]),
         .avail  (avails[k]),
         .result (results[k])
      );

      assign match_vec[k] = fvalid_ff && results[k].hit
                            && (feos_ff || (k == 0 && flen_ff == count_type'(WINDOW_DEPTH)));
   end

   always_comb begin
      remain = match_vec & ~done_ff;
      lowest = remain & (~remain + 1'b1);
      last   = (remain == lowest);
      sel    = '0;
      for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
         if (remain[i]) begin
            sel = count_type'(i);
         end
      end
      out_ready  = !rsp_valid_ff || !rsp_stall;
      emit       = out_ready && (remain != '0);
      frame_free = !fvalid_ff || (remain == '0) || (emit && last);
      offset_sum = {1'b0, fpos_ff} + (POS_WIDTH+1)'(sel);
      offset_sat = offset_sum[POS_WIDTH] ? '1 : offset_sum[POS_WIDTH-1:0];
   end

   assign req_stall = !frame_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= 1'b0;
         done_ff   <= '0;
      end else if (accept) begin
         fvalid_ff <= 1'b1;
         done_ff   <= '0;
      end else if (frame_free) begin
         fvalid_ff <= 1'b0;
      end else if (emit) begin
         done_ff <= done_ff | lowest;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         frame_ff <= frame_in;
         flen_ff  <= flen_in;
         fpos_ff  <= pos_ff;
         feos_ff  <= req_end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         offset_ff <= OFFSET_WIDTH'(offset_sat);
         result_ff <= results[sel];
         last_ff   <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_offset  = offset_ff;
   assign rsp_is_jump       = result_ff.is_jump;
   assign rsp_base_register = result_ff.base_register;
   assign rsp_address_mode  = result_ff.address_mode;
   assign rsp_displacement  = result_ff.displacement;
   assign rsp_last_of_run   = last_ff;

endmodule
